// ===== src/mkbp_pkg.sv =====
// Package for the motor knob and button panel.
// Holds field widths, register indexes, input codes and reset values.
// Used by the panel top level and its port checker; depends on nothing.
package mkbp_pkg;

	localparam int unsigned TIME_BITS_DEF = 32;

	localparam int unsigned SPEED_W   = 9;
	localparam int unsigned CURRENT_W = 4;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CURRENT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_TICKS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_INTERVAL = 3'd4;

	// Knob step codes
	localparam logic [1:0] KNOB_NONE = 2'd0;
	localparam logic [1:0] KNOB_CW   = 2'd1;
	localparam logic [1:0] KNOB_CCW  = 2'd2;

	// System mode codes
	localparam logic [1:0] MODE_OFF       = 2'd0;
	localparam logic [1:0] MODE_RETRACTED = 2'd1;
	localparam logic [1:0] MODE_RUNNING   = 2'd2;

	// Register reset values
	localparam logic [7:0]           MAX_SPEED_RST      = 8'd200;
	localparam logic [CURRENT_W-1:0] MAX_CURRENT_RST    = 4'd14;
	localparam logic [15:0]          REVERSE_TICKS_RST  = 16'd10000;
	localparam logic [15:0]          DEBOUNCE_RST       = 16'd250;
	localparam logic [7:0]           CHECK_INTERVAL_RST = 8'd100;

	// State reset values
	localparam logic [CURRENT_W-1:0] CURRENT_LIMIT_RST = 4'd4;

endpackage

// ===== src/motor_knob_button_panel.sv =====
// Motor knob and button panel: mode toggle, speed and current targets, reverse timeout.
// Single-pass datapath between an input stage and a result register.
// Depends on mkbp_pkg.
//
// Usage: one input transaction per 1 ms tick carries the raw button level, the knob step
// and the system mode. Each input transaction yields exactly one result transaction with
// both motor speed commands, the current limit, the mode flag and the disable request.
// out_valid rises only after an accepted transaction has passed the input stage and then
// the result register. Throughput is one transaction per cycle while the receiver does
// not stall; all per-tick work (debounce subtract and compare, clamping, reverse counter)
// is combinational between the input stage and the result register.
// The result register is separate from the input stage, so a new input transaction is
// taken while a result waits. When the receiver stalls, the result holds and the input
// stage fills; in_ready falls only once both are occupied.
// Configuration writes go through the cfg channel, which is always ready; indexes beyond
// the register list are ignored. Reset restores every register and the panel state to
// their power-up values (speed mode, zero speed, 2.0 A) and empties the pipeline.
module motor_knob_button_panel #(
	parameter int unsigned TIME_BITS = mkbp_pkg::TIME_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [mkbp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mkbp_pkg::CFG_DATA_W-1:0]        cfg_data,

	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   button_level,
	input  logic [1:0]                             knob_step,
	input  logic [1:0]                             system_mode,

	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [mkbp_pkg::SPEED_W-1:0]    motor_one_speed,
	output logic signed [mkbp_pkg::SPEED_W-1:0]    motor_two_speed,
	output logic [mkbp_pkg::CURRENT_W-1:0]         current_limit_out,
	output logic                                   speed_mode_out,
	output logic                                   disable_request
);

	// Configuration registers
	logic [7:0]                       max_speed_q;
	logic [mkbp_pkg::CURRENT_W-1:0]   max_current_q;
	logic [15:0]                      reverse_ticks_q;
	logic [15:0]                      debounce_q;
	logic [7:0]                       check_interval_q;

	// Panel state
	logic [TIME_BITS-1:0]             tick_time_q;
	logic [7:0]                       sample_phase_q;
	logic [TIME_BITS-1:0]             last_press_q;
	logic                             prev_button_q;
	logic                             speed_mode_q;
	logic signed [mkbp_pkg::SPEED_W-1:0] speed_target_q;
	logic [mkbp_pkg::CURRENT_W-1:0]   current_limit_q;
	logic [15:0]                      reverse_count_q;

	// Input stage
	logic                             valid_s1;
	logic                             button_s1;
	logic [1:0]                       knob_s1;
	logic [1:0]                       mode_s1;

	// Result register
	logic                             out_valid_q;
	logic signed [mkbp_pkg::SPEED_W-1:0] motor_one_q;
	logic signed [mkbp_pkg::SPEED_W-1:0] motor_two_q;
	logic [mkbp_pkg::CURRENT_W-1:0]   current_out_q;
	logic                             speed_mode_out_q;
	logic                             disable_q;

	logic                             accept;
	logic                             advance;

	// Combinational next-state values
	logic [7:0]                       period;
	logic                             sample;
	logic [8:0]                       phase_inc;
	logic [7:0]                       phase_next;
	logic [TIME_BITS-1:0]             press_base;
	logic [TIME_BITS-1:0]             elapsed;
	logic                             pressed;
	logic [TIME_BITS-1:0]             last_press_next;
	logic                             prev_button_next;
	logic                             speed_mode_next;
	logic signed [1:0]                delta;
	logic signed [9:0]                speed_sum;
	logic signed [9:0]                speed_hi;
	logic signed [9:0]                speed_lo;
	logic signed [mkbp_pkg::SPEED_W-1:0] speed_target_next;
	logic signed [5:0]                current_sum;
	logic signed [5:0]                current_hi;
	logic [mkbp_pkg::CURRENT_W-1:0]   current_limit_next;
	logic [15:0]                      reverse_count_next;
	logic                             swap;
	logic                             disable_next;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign accept    = in_valid && in_ready;

	always_comb begin
		// Button sampling: once per check interval, a zero interval meaning every tick
		period    = (check_interval_q == 8'd0) ? 8'd1 : check_interval_q;
		sample    = (sample_phase_q == 8'd0);
		phase_inc = {1'b0, sample_phase_q} + 9'd1;
		phase_next = (phase_inc >= {1'b0, period}) ? 8'd0 : phase_inc[7:0];

		// After the tick counter wraps, the last press time is pulled back to now.
		press_base = (tick_time_q < last_press_q) ? tick_time_q : last_press_q;
		elapsed    = tick_time_q - press_base;
		pressed    = sample && !button_s1 && prev_button_q &&
			(elapsed > TIME_BITS'(debounce_q));

		last_press_next  = last_press_q;
		prev_button_next = prev_button_q;
		if (sample) begin
			last_press_next  = pressed ? tick_time_q : press_base;
			prev_button_next = button_s1;
		end
		speed_mode_next = speed_mode_q ^ pressed;

		case (knob_s1)
			mkbp_pkg::KNOB_CW:  delta = 2'sb01;
			mkbp_pkg::KNOB_CCW: delta = 2'sb11;
			default:            delta = 2'sb00;
		endcase

		// Speed target clamp to plus or minus the maximum speed
		speed_sum = $signed({speed_target_q[mkbp_pkg::SPEED_W-1], speed_target_q}) +
			$signed({{8{delta[1]}}, delta});
		speed_hi  = $signed({2'b00, max_speed_q});
		speed_lo  = -speed_hi;

		// Current limit clamp to zero and the maximum current
		current_sum = $signed({2'b00, current_limit_q}) + $signed({{4{delta[1]}}, delta});
		current_hi  = $signed({2'b00, max_current_q});

		speed_target_next  = speed_target_q;
		current_limit_next = current_limit_q;
		if (mode_s1 != mkbp_pkg::MODE_OFF) begin
			if (speed_mode_next) begin
				if (speed_sum > speed_hi) begin
					speed_target_next = speed_hi[mkbp_pkg::SPEED_W-1:0];
				end else if (speed_sum < speed_lo) begin
					speed_target_next = speed_lo[mkbp_pkg::SPEED_W-1:0];
				end else begin
					speed_target_next = speed_sum[mkbp_pkg::SPEED_W-1:0];
				end
			end else begin
				if (current_sum > current_hi) begin
					current_limit_next = max_current_q;
				end else if (current_sum < 6'sd0) begin
					current_limit_next = '0;
				end else begin
					current_limit_next = current_sum[mkbp_pkg::CURRENT_W-1:0];
				end
			end
		end

		// Reverse spin while retracted, until the allowance is used up
		swap         = 1'b0;
		disable_next = 1'b0;
		reverse_count_next = '0;
		if (mode_s1 == mkbp_pkg::MODE_RETRACTED) begin
			if (reverse_count_q < reverse_ticks_q) begin
				reverse_count_next = reverse_count_q + 16'd1;
				swap = 1'b1;
			end else begin
				reverse_count_next = reverse_count_q;
				disable_next = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q      <= mkbp_pkg::MAX_SPEED_RST;
			max_current_q    <= mkbp_pkg::MAX_CURRENT_RST;
			reverse_ticks_q  <= mkbp_pkg::REVERSE_TICKS_RST;
			debounce_q       <= mkbp_pkg::DEBOUNCE_RST;
			check_interval_q <= mkbp_pkg::CHECK_INTERVAL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mkbp_pkg::REG_MAX_SPEED:      max_speed_q      <= cfg_data[7:0];
				mkbp_pkg::REG_MAX_CURRENT:    max_current_q    <= cfg_data[mkbp_pkg::CURRENT_W-1:0];
				mkbp_pkg::REG_REVERSE_TICKS:  reverse_ticks_q  <= cfg_data;
				mkbp_pkg::REG_DEBOUNCE:       debounce_q       <= cfg_data;
				mkbp_pkg::REG_CHECK_INTERVAL: check_interval_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_time_q     <= '0;
			sample_phase_q  <= '0;
			last_press_q    <= '0;
			prev_button_q   <= 1'b1;
			speed_mode_q    <= 1'b1;
			speed_target_q  <= '0;
			current_limit_q <= mkbp_pkg::CURRENT_LIMIT_RST;
			reverse_count_q <= '0;
		end else if (advance) begin
			tick_time_q     <= tick_time_q + TIME_BITS'(1);
			sample_phase_q  <= phase_next;
			last_press_q    <= last_press_next;
			prev_button_q   <= prev_button_next;
			speed_mode_q    <= speed_mode_next;
			speed_target_q  <= speed_target_next;
			current_limit_q <= current_limit_next;
			reverse_count_q <= reverse_count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			button_s1 <= button_level;
			knob_s1   <= knob_step;
			mode_s1   <= system_mode;
		end
		if (advance) begin
			motor_one_q      <= swap ? speed_target_next : -speed_target_next;
			motor_two_q      <= swap ? -speed_target_next : speed_target_next;
			current_out_q    <= current_limit_next;
			speed_mode_out_q <= speed_mode_next;
			disable_q        <= disable_next;
		end
	end

	assign out_valid         = out_valid_q;
	assign motor_one_speed   = motor_one_q;
	assign motor_two_speed   = motor_two_q;
	assign current_limit_out = current_out_q;
	assign speed_mode_out    = speed_mode_out_q;
	assign disable_request   = disable_q;

endmodule

// ===== src/mkbp_checker.sv =====
// Port-level checker for the motor knob and button panel, bound to the top level.
// Watches the input and result channels only; depends on mkbp_pkg for field widths.
module mkbp_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [mkbp_pkg::SPEED_W-1:0] motor_one_speed,
	input  logic signed [mkbp_pkg::SPEED_W-1:0] motor_two_speed
);

	// A stalled result transaction keeps its valid and its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(motor_one_speed) &&
			$stable(motor_two_speed))
		else $error("stalled result changed or was dropped");

	// The two motors always spin in opposite directions.
	a_opposite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (motor_one_speed + motor_two_speed) == '0)
		else $error("motor speed commands are not opposite");

	// With the result register empty, the block never holds off the sender.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while no result is pending");

	// A result appearing from an empty output comes from a transaction that passed the input
	// stage and then the result register.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without a matching input transaction");

endmodule

bind motor_knob_button_panel mkbp_checker u_mkbp_checker (.*);
